FILE: rtl/core/ptb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, sizes and codes of the palindromic tree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int MAX_LEN      = 1024;
    localparam int MAX_ALPHABET = 32;
    localparam int NODE_CAP     = MAX_LEN + 2;
    localparam int CH_DEPTH     = NODE_CAP * MAX_ALPHABET;
    localparam int IDX_W        = 11;
    localparam int SYM_W        = 5;
    localparam int STR_AW       = 10;
    localparam int CH_AW        = $clog2(CH_DEPTH);
    localparam int SUM_W        = 20;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHAR_BASE = 1'b0;
    localparam logic CFG_ALPHA     = 1'b1;

    // datapath operations
    localparam logic [3:0] OP_IDLE     = 4'd0;
    localparam logic [3:0] OP_CLR      = 4'd1;
    localparam logic [3:0] OP_ACCEPT   = 4'd2;
    localparam logic [3:0] OP_CHECK    = 4'd3;
    localparam logic [3:0] OP_NODE_RD  = 4'd4;
    localparam logic [3:0] OP_EVAL     = 4'd5;
    localparam logic [3:0] OP_CMP      = 4'd6;
    localparam logic [3:0] OP_FOUND    = 4'd7;
    localparam logic [3:0] OP_CH_CHK   = 4'd8;
    localparam logic [3:0] OP_NXT_EVAL = 4'd9;
    localparam logic [3:0] OP_NEW      = 4'd10;
    localparam logic [3:0] OP_IGN      = 4'd11;

    typedef struct packed {
        logic [7:0] char_code;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] suffix_len;
        logic [IDX_W-1:0] node_index;
        logic             is_new;
        logic [IDX_W-1:0] suffix_count;
        logic [IDX_W-1:0] distinct_count;
        logic [SUM_W-1:0] total_palindromes;
        logic [IDX_W-1:0] first_end_pos;
        logic [IDX_W-1:0] node_hits;
    } t_out;

    typedef struct packed {
        logic [IDX_W-1:0]  link;
        logic signed [11:0] len;
        logic [IDX_W-1:0]  sufcnt;
        logic [IDX_W-1:0]  fpos;
        logic [IDX_W-1:0]  hits;
        logic [IDX_W-1:0]  parent;
        logic [SYM_W-1:0]  pchar;
    } t_node;

    typedef struct packed {
        logic [3:0] op;
        logic       pass;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic full;
        logic imm_hit;
        logic imm_miss;
        logic str_eq;
        logic clr_done;
        logic nxt_ok;
        logic len_one;
    } t_dp_stat;

endpackage

FILE: rtl/core/palindromic_tree_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder
// Online eertree builder: one character per command, one result per command.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  --------  --------------------------------------  -------------------------
//  command   start, busy, i_item                     start & !busy
//  result    o_done, o_result                        o_done (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,  i_cfg_valid & o_cfg_ready
//            i_cfg_data
//
//  an ignored character passes the check and ignore states; an accepted one
//  walks suffix links, each step a node memory read and, where the length
//  does not settle it, a string compare, then a child lookup and node update;
//  a new node adds a state, and for a length above one a second walk and lookup
//  after reset all 32832 child table entries are cleared with busy high
//  the result is shown for exactly one cycle and cannot be held off
// ----------------------------------------------------------------------------
module palindromic_tree_builder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ptb_pkg::t_in   i_item,
    output logic           o_done,
    output ptb_pkg::t_out  o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [7:0]     i_cfg_data
);

    ptb_pkg::t_dp_cmd  cmd;
    ptb_pkg::t_dp_stat stat;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer
    ptb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // tree storage and arithmetic
    ptb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

FILE: rtl/core/ptb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ptb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: clearing pass, suffix link walks, child lookup, node update.
// ----------------------------------------------------------------------------
module ptb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ptb_pkg::t_dp_stat i_stat,
    output ptb_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_NODE_RD  = 4'd3;
    localparam logic [3:0] S_EVAL     = 4'd4;
    localparam logic [3:0] S_CMP      = 4'd5;
    localparam logic [3:0] S_FOUND    = 4'd6;
    localparam logic [3:0] S_CH_CHK   = 4'd7;
    localparam logic [3:0] S_NXT_EVAL = 4'd8;
    localparam logic [3:0] S_NEW      = 4'd9;
    localparam logic [3:0] S_IGN      = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_cmd.op   = ptb_pkg::OP_IDLE;
        o_cmd.pass = r_pass;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = ptb_pkg::OP_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = ptb_pkg::OP_ACCEPT;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = ptb_pkg::OP_CHECK;
                n_pass   = 1'b0;
                n_state  = (i_stat.bad || i_stat.full) ? S_IGN : S_NODE_RD;
            end
            S_NODE_RD: begin
                o_cmd.op = ptb_pkg::OP_NODE_RD;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.op = ptb_pkg::OP_EVAL;
                if (i_stat.imm_hit)       n_state = S_FOUND;
                else if (i_stat.imm_miss) n_state = S_NODE_RD;
                else                      n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = ptb_pkg::OP_CMP;
                n_state  = i_stat.str_eq ? S_FOUND : S_NODE_RD;
            end
            S_FOUND: begin
                o_cmd.op = ptb_pkg::OP_FOUND;
                n_state  = S_CH_CHK;
            end
            S_CH_CHK: begin
                o_cmd.op = ptb_pkg::OP_CH_CHK;
                n_state  = S_NXT_EVAL;
            end
            S_NXT_EVAL: begin
                o_cmd.op = ptb_pkg::OP_NXT_EVAL;
                n_state  = (!r_pass && !i_stat.nxt_ok) ? S_NEW : S_OUT;
            end
            S_NEW: begin
                o_cmd.op = ptb_pkg::OP_NEW;
                if (i_stat.len_one) begin
                    n_state = S_OUT;
                end else begin
                    n_pass  = 1'b1;
                    n_state = S_NODE_RD;
                end
            end
            S_IGN: begin
                o_cmd.op = ptb_pkg::OP_IGN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

FILE: rtl/core/ptb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_dp
// Datapath: string, node and child memories, tree registers, result.
// ----------------------------------------------------------------------------
module ptb_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptb_pkg::t_in      i_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  ptb_pkg::t_dp_cmd  i_cmd,
    output ptb_pkg::t_dp_stat o_stat,
    output ptb_pkg::t_out     o_result
);

    localparam int IW = ptb_pkg::IDX_W;
    localparam int NW = $bits(ptb_pkg::t_node);

    logic [7:0]              r_char_base;
    logic [5:0]              r_alpha;
    logic [7:0]              r_ch;
    logic [ptb_pkg::SYM_W-1:0] r_c, n_c;
    logic [IW-1:0]           r_pos, r_nt, r_long, r_v, r_link, r_cur, r_cur_link;
    logic [IW-1:0]           r_nxt, r_nn, r_res_v, r_nrd_addr;
    logic signed [11:0]      r_len, r_cur_len;
    logic [ptb_pkg::SUM_W-1:0] r_sum;
    ptb_pkg::t_node          r_rec;
    logic [1:0]              r_status;
    logic                    r_is_new;
    logic [ptb_pkg::CH_AW-1:0] r_clr;

    logic [IW-1:0]           n_pos, n_nt, n_long, n_v, n_link, n_cur, n_cur_link;
    logic [IW-1:0]           n_nxt, n_nn, n_res_v, n_nrd_addr;
    logic signed [11:0]      n_len, n_cur_len;
    logic [ptb_pkg::SUM_W-1:0] n_sum;
    ptb_pkg::t_node          n_rec;
    logic [1:0]              n_status;
    logic                    n_is_new;
    logic [ptb_pkg::CH_AW-1:0] n_clr;
    logic [7:0]              n_ch;

    // memory ports
    logic                        str_we;
    logic [ptb_pkg::STR_AW-1:0]  str_waddr, str_raddr;
    logic [7:0]                  str_rdata;
    logic                        node_we;
    logic [IW-1:0]               node_waddr;
    ptb_pkg::t_node              node_wdata;
    logic [NW-1:0]               node_rdata;
    logic                        ch_we;
    logic [ptb_pkg::CH_AW-1:0]   ch_waddr, ch_raddr;
    logic [IW-1:0]               ch_wdata, ch_rdata;

    ptb_ram #(.WIDTH(8), .DEPTH(ptb_pkg::MAX_LEN)) u_str_ram (
        .i_clk(i_clk), .i_we(str_we), .i_waddr(str_waddr), .i_wdata(r_ch),
        .i_raddr(str_raddr), .o_rdata(str_rdata)
    );

    ptb_ram #(.WIDTH(NW), .DEPTH(ptb_pkg::NODE_CAP)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(n_nrd_addr), .o_rdata(node_rdata)
    );

    ptb_ram #(.WIDTH(IW), .DEPTH(ptb_pkg::CH_DEPTH)) u_child_ram (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_raddr(ch_raddr), .o_rdata(ch_rdata)
    );

    // node record as read, roots are constants
    ptb_pkg::t_node rec, root_rec, new_rec;
    logic [5:0]         sigma;
    logic [7:0]         diff;
    logic signed [12:0] j;
    logic [IW-1:0]      nn_c, lk_c, sc_c;

    always_comb begin
        root_rec     = '0;
        root_rec.len = (r_nrd_addr == '0) ? -12'sd1 : 12'sd0;
        rec          = (r_nrd_addr < IW'(2)) ? root_rec : ptb_pkg::t_node'(node_rdata);
        sigma        = (r_alpha > 6'(ptb_pkg::MAX_ALPHABET)) ?
                       6'(ptb_pkg::MAX_ALPHABET) : r_alpha;
        diff         = r_ch - r_char_base;
        j            = $signed({2'b00, r_pos}) - 13'sd1 - 13'(rec.len);

        o_stat.bad      = (r_ch < r_char_base) || (diff >= {2'b00, sigma});
        o_stat.full     = (r_pos >= IW'(ptb_pkg::MAX_LEN));
        o_stat.imm_hit  = (rec.len < 12'sd0);
        o_stat.imm_miss = !(rec.len < 12'sd0) && (j < 13'sd1);
        o_stat.str_eq   = (str_rdata == r_ch);
        o_stat.clr_done = (r_clr == ptb_pkg::CH_AW'(ptb_pkg::CH_DEPTH - 1));
        o_stat.nxt_ok   = (r_nxt >= IW'(2)) && (r_nxt < r_nt) &&
                          (rec.parent == r_v) && (rec.pchar == r_c);
        o_stat.len_one  = (r_cur_len < 12'sd0);
    end

    // new node record: link and its suffix count depend on the path taken
    always_comb begin
        if (i_cmd.op == ptb_pkg::OP_NEW) begin
            nn_c = r_nt;
            lk_c = IW'(1);
            sc_c = '0;
        end else begin
            nn_c = r_nn;
            lk_c = o_stat.nxt_ok ? r_nxt : IW'(1);
            sc_c = o_stat.nxt_ok ? rec.sufcnt : '0;
        end
        new_rec.link   = lk_c;
        new_rec.len    = r_cur_len + 12'sd2;
        new_rec.sufcnt = sc_c + IW'(1);
        new_rec.fpos   = r_pos;
        new_rec.hits   = IW'(1);
        new_rec.parent = r_cur;
        new_rec.pchar  = r_c;
    end

    always_comb begin
        n_ch = r_ch; n_c = r_c; n_pos = r_pos; n_nt = r_nt; n_long = r_long;
        n_v = r_v; n_link = r_link; n_len = r_len; n_cur = r_cur;
        n_cur_link = r_cur_link; n_cur_len = r_cur_len; n_nxt = r_nxt; n_nn = r_nn;
        n_res_v = r_res_v; n_rec = r_rec; n_status = r_status; n_is_new = r_is_new;
        n_sum = r_sum; n_clr = r_clr; n_nrd_addr = r_nrd_addr;
        str_we = 1'b0; str_waddr = r_pos[ptb_pkg::STR_AW-1:0];
        str_raddr = ptb_pkg::STR_AW'(j) - ptb_pkg::STR_AW'(1);
        node_we = 1'b0; node_waddr = r_nxt; node_wdata = new_rec;
        ch_we = 1'b0; ch_waddr = r_clr; ch_wdata = '0;
        ch_raddr = {r_v, r_c};

        case (i_cmd.op)
            ptb_pkg::OP_CLR: begin
                ch_we = 1'b1;
                n_clr = r_clr + ptb_pkg::CH_AW'(1);
            end
            ptb_pkg::OP_ACCEPT: begin
                n_ch = i_item.char_code;
                if (i_item.restart) begin
                    n_nt   = IW'(2);
                    n_long = IW'(1);
                    n_pos  = '0;
                    n_sum  = '0;
                end
            end
            ptb_pkg::OP_CHECK: begin
                n_c      = diff[ptb_pkg::SYM_W-1:0];
                n_is_new = 1'b0;
                if (o_stat.bad || o_stat.full) begin
                    n_status   = o_stat.bad ? ptb_pkg::ST_BAD_CHAR : ptb_pkg::ST_FULL;
                    n_nrd_addr = r_long;
                end else begin
                    n_status = ptb_pkg::ST_OK;
                    str_we   = 1'b1;
                    n_pos    = r_pos + IW'(1);
                    n_v      = r_long;
                end
            end
            ptb_pkg::OP_NODE_RD: begin
                n_nrd_addr = r_v;
            end
            ptb_pkg::OP_EVAL: begin
                n_link = rec.link;
                n_len  = rec.len;
                if (o_stat.imm_miss) n_v = rec.link;
            end
            ptb_pkg::OP_CMP: begin
                if (!o_stat.str_eq) n_v = r_link;
            end
            ptb_pkg::OP_FOUND: begin
                if (!i_cmd.pass) begin
                    n_cur      = r_v;
                    n_cur_len  = r_len;
                    n_cur_link = r_link;
                end
            end
            ptb_pkg::OP_CH_CHK: begin
                n_nxt      = ch_rdata;
                n_nrd_addr = ch_rdata;
            end
            ptb_pkg::OP_NXT_EVAL: begin
                if (!i_cmd.pass) begin
                    if (o_stat.nxt_ok) begin
                        node_we         = 1'b1;
                        node_waddr      = r_nxt;
                        node_wdata      = rec;
                        node_wdata.hits = rec.hits + IW'(1);
                        n_rec           = node_wdata;
                        n_long          = r_nxt;
                        n_res_v         = r_nxt;
                        n_sum           = r_sum + ptb_pkg::SUM_W'(rec.sufcnt);
                    end
                end else begin
                    node_we    = 1'b1;
                    node_waddr = nn_c;
                    n_rec      = new_rec;
                    n_long     = nn_c;
                    n_res_v    = nn_c;
                    n_is_new   = 1'b1;
                    n_sum      = r_sum + ptb_pkg::SUM_W'(new_rec.sufcnt);
                end
            end
            ptb_pkg::OP_NEW: begin
                n_nn     = r_nt;
                n_nt     = r_nt + IW'(1);
                ch_we    = 1'b1;
                ch_waddr = {r_cur, r_c};
                ch_wdata = r_nt;
                if (o_stat.len_one) begin
                    node_we    = 1'b1;
                    node_waddr = nn_c;
                    n_rec      = new_rec;
                    n_long     = nn_c;
                    n_res_v    = nn_c;
                    n_is_new   = 1'b1;
                    n_sum      = r_sum + ptb_pkg::SUM_W'(new_rec.sufcnt);
                end else begin
                    n_v = r_cur_link;
                end
            end
            ptb_pkg::OP_IGN: begin
                n_rec   = rec;
                n_res_v = r_long;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_base <= 8'd97;
            r_alpha     <= 6'd26;
            r_nt        <= IW'(2);
            r_long      <= IW'(1);
            r_pos       <= '0;
            r_sum       <= '0;
            r_clr       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ptb_pkg::CFG_CHAR_BASE: r_char_base <= i_cfg_data;
                    ptb_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            r_nt   <= n_nt;
            r_long <= n_long;
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_clr  <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch; r_c <= n_c; r_v <= n_v; r_link <= n_link; r_len <= n_len;
        r_cur <= n_cur; r_cur_len <= n_cur_len; r_cur_link <= n_cur_link;
        r_nxt <= n_nxt; r_nn <= n_nn; r_res_v <= n_res_v; r_rec <= n_rec;
        r_status <= n_status; r_is_new <= n_is_new; r_nrd_addr <= n_nrd_addr;
    end

    logic root;
    always_comb begin
        root                       = (r_res_v < IW'(2));
        o_result.status            = r_status;
        o_result.suffix_len        = (root || r_rec.len < 12'sd0) ? '0 : r_rec.len[IW-1:0];
        o_result.node_index        = r_res_v;
        o_result.is_new            = r_is_new;
        o_result.suffix_count      = root ? '0 : r_rec.sufcnt;
        o_result.distinct_count    = r_nt - IW'(2);
        o_result.total_palindromes = r_sum;
        o_result.first_end_pos     = root ? '0 : r_rec.fpos;
        o_result.node_hits         = root ? '0 : r_rec.hits;
    end

endmodule
